// ===== sv/stq_pkg.sv =====
// Package for the sorted timer queue: sizes, slot entry type, action codes
// and sequencer states. No dependencies.
`default_nettype none

package stq_pkg;

	localparam int SLOTS     = 16;
	localparam int TIME_BITS = 32;
	localparam int ID_W      = 4;
	localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W     = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ACT_ADD_ONE = 2'd0,
		ACT_ADD_PER = 2'd1,
		ACT_DEL     = 2'd2,
		ACT_TICK    = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIND,
		ST_PREP,
		ST_INS,
		ST_TSCAN,
		ST_TPOP
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [TIME_BITS-1:0] expiry;
		logic [TIME_BITS-1:0] period;
		logic                 periodic;
	} entry_t;

endpackage

`default_nettype wire

// ===== sv/sorted_timer_queue.sv =====
// Sorted timer queue: packed slot list kept in expiry order, walked by a
// sequencer around one shared adder and one shared compare.
// Depends on stq_pkg.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------
//  in      | in  | in_valid/in_stall  | action, timer_id, interval, now
//  out     | out | out_valid/out_stall| fired_id, last
//
// Add: id scan, then the insert scan through the shared compare; delete:
// id scan only. Tick: a scan over the expired timers, then one pop per
// fired timer, each periodic one followed by its reinsert scan. A pop waits
// while the output register is full and out_stall is high.
// Reset clears the state, slot count and output valid flag; the store
// needs no clearing pass. in_stall is high whenever the sequencer is busy.
`default_nettype none

module sorted_timer_queue import stq_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	input  wire logic [ID_W-1:0]      timer_id,
	input  wire logic [TIME_BITS-1:0] interval,
	input  wire logic [TIME_BITS-1:0] now,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [ID_W-1:0]           fired_id,
	output logic                      last
);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [CNT_W-1:0] p_q, p_d;
	logic [CNT_W-1:0] rem_q, rem_d;
	logic             out_valid_q;

	action_t              act_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] ival_q;
	logic [TIME_BITS-1:0] now_q;
	entry_t               ins_q;
	entry_t               slot_q [SLOTS];
	logic [ID_W-1:0]      fired_id_q;
	logic                 last_q;

	entry_t               rd;
	entry_t               head;
	logic [TIME_BITS-1:0] add_a, add_b, sum;
	logic [TIME_BITS-1:0] cmp_a, cmp_b;
	logic                 cmp_le;
	logic                 in_acc;
	logic                 out_free;
	logic                 shl, shr;
	logic [IDX_W-1:0]     sp;
	logic                 ld_add, ld_pop, ld_out;

	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign rd       = slot_q[p_q[IDX_W-1:0]];
	assign head     = slot_q[0];

	// shared adder and compare
	always_comb begin
		if (state_q == ST_TPOP) begin
			add_a = head.expiry;
			add_b = head.period;
		end else begin
			add_a = now_q;
			add_b = ival_q;
		end
		if (state_q == ST_TSCAN) begin
			cmp_a = rd.expiry;
			cmp_b = now_q;
		end else begin
			cmp_a = ins_q.expiry;
			cmp_b = rd.expiry;
		end
	end
	assign sum    = add_a + add_b;
	assign cmp_le = (cmp_a <= cmp_b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			p_q         <= '0;
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			p_q     <= p_d;
			rem_q   <= rem_d;
			if (ld_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		p_d      = p_q;
		rem_d    = rem_q;
		shl      = 1'b0;
		shr      = 1'b0;
		sp       = p_q[IDX_W-1:0];
		ld_add   = 1'b0;
		ld_pop   = 1'b0;
		ld_out   = 1'b0;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				p_d = '0;
				if (in_valid) begin
					if (action_t'(action) == ACT_TICK)
						state_d = ST_TSCAN;
					else
						state_d = ST_FIND;
				end
			end
			ST_FIND: begin
				if (p_q == cnt_q) begin
					state_d = ST_PREP;
				end else if (rd.id == id_q) begin
					shl     = 1'b1;
					cnt_d   = cnt_q - 1'b1;
					state_d = ST_PREP;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			ST_PREP: begin
				p_d = '0;
				if (act_q == ACT_DEL || cnt_q == CNT_W'(SLOTS)) begin
					state_d = ST_IDLE;
				end else begin
					ld_add  = 1'b1;
					state_d = ST_INS;
				end
			end
			ST_INS: begin
				if (p_q == cnt_q || cmp_le) begin
					shr   = 1'b1;
					cnt_d = cnt_q + 1'b1;
					if (act_q == ACT_TICK && rem_q != '0)
						state_d = ST_TPOP;
					else
						state_d = ST_IDLE;
				end else begin
					p_d = p_q + 1'b1;
				end
			end
			ST_TSCAN: begin
				if (p_q != cnt_q && cmp_le) begin
					p_d = p_q + 1'b1;
				end else begin
					rem_d = p_q;
					if (p_q == '0)
						state_d = ST_IDLE;
					else
						state_d = ST_TPOP;
				end
			end
			ST_TPOP: begin
				sp = '0;
				if (out_free) begin
					ld_out = 1'b1;
					ld_pop = 1'b1;
					shl    = 1'b1;
					cnt_d  = cnt_q - 1'b1;
					rem_d  = rem_q - 1'b1;
					if (head.periodic) begin
						p_d     = rem_q - 1'b1;
						state_d = ST_INS;
					end else if (rem_q == CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q  <= action_t'(action);
			id_q   <= timer_id;
			ival_q <= interval;
			now_q  <= now;
		end
		if (ld_add) begin
			ins_q.id       <= id_q;
			ins_q.expiry   <= sum;
			ins_q.period   <= (act_q == ACT_ADD_PER) ? ival_q : '0;
			ins_q.periodic <= (act_q == ACT_ADD_PER);
		end else if (ld_pop) begin
			ins_q.id       <= head.id;
			ins_q.expiry   <= sum;
			ins_q.period   <= head.period;
			ins_q.periodic <= 1'b1;
		end
		if (ld_out) begin
			fired_id_q <= head.id;
			last_q     <= (rem_q == CNT_W'(1));
		end
	end

	for (genvar g = 0; g < SLOTS; g++) begin : g_slot
		localparam int UP = (g + 1 < SLOTS) ? g + 1 : g;
		localparam int DN = (g > 0) ? g - 1 : 0;
		always_ff @(posedge clk) begin
			if (shr && IDX_W'(g) == sp)
				slot_q[g] <= ins_q;
			else if (shr && IDX_W'(g) > sp)
				slot_q[g] <= slot_q[DN];
			else if (shl && IDX_W'(g) >= sp && g < SLOTS - 1)
				slot_q[g] <= slot_q[UP];
		end
	end

	assign out_valid = out_valid_q;
	assign fired_id  = fired_id_q;
	assign last      = last_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(SLOTS))
		else $error("slot count beyond capacity");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_INS |-> cnt_q < CNT_W'(SLOTS))
		else $error("insert with full store");

	a_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TPOP |-> rem_q != '0 && rem_q <= cnt_q)
		else $error("expired count out of range");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && cnt_q >= CNT_W'(2) |->
			slot_q[0].expiry <= slot_q[1].expiry)
		else $error("list head out of order");

	a_pop_out: assert property (@(posedge clk) disable iff (!arst_n)
		ld_out |=> out_valid_q && fired_id_q == $past(head.id))
		else $error("fired beat not registered");

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for sorted_timer_queue: drives random add, delete and tick beats
// with random idling, predicts fired ids against its own sorted timer list.
// Depends on stq_pkg and sorted_timer_queue.
`default_nettype none

module tb;
	import stq_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            last;
	} fire_t;

	class expiry_list;
		logic [ID_W-1:0]      ids  [SLOTS];
		logic [TIME_BITS-1:0] exps [SLOTS];
		logic [TIME_BITS-1:0] pers [SLOTS];
		logic                 prds [SLOTS];
		int                   count;
		fire_t                pending_fires[$];
		int                   mismatches;

		function new();
			count = 0;
			mismatches = 0;
		endfunction

		function void drop_at(int p);
			for (int i = p; i + 1 < count; i++) begin
				ids[i]  = ids[i+1];
				exps[i] = exps[i+1];
				pers[i] = pers[i+1];
				prds[i] = prds[i+1];
			end
			count--;
		endfunction

		function void drop_id(logic [ID_W-1:0] id);
			for (int i = 0; i < count; i++) begin
				if (ids[i] == id) begin
					drop_at(i);
					return;
				end
			end
		endfunction

		function void insert(logic [ID_W-1:0] id, logic [TIME_BITS-1:0] e,
				logic [TIME_BITS-1:0] per, logic prd);
			int p;
			p = 0;
			if (count >= SLOTS)
				return;
			while (p < count && e > exps[p])
				p++;
			for (int i = count; i > p; i--) begin
				ids[i]  = ids[i-1];
				exps[i] = exps[i-1];
				pers[i] = pers[i-1];
				prds[i] = prds[i-1];
			end
			ids[p]  = id;
			exps[p] = e;
			pers[p] = per;
			prds[p] = prd;
			count++;
		endfunction

		function void apply_item(action_t act, logic [ID_W-1:0] id,
				logic [TIME_BITS-1:0] ivl, logic [TIME_BITS-1:0] t);
			logic [ID_W-1:0]      f_id  [SLOTS];
			logic [TIME_BITS-1:0] f_exp [SLOTS];
			logic [TIME_BITS-1:0] f_per [SLOTS];
			logic                 f_prd [SLOTS];
			logic [TIME_BITS-1:0] sum;
			fire_t                f;
			int                   k;
			case (act)
				ACT_ADD_ONE, ACT_ADD_PER: begin
					drop_id(id);
					sum = t + ivl;
					insert(id, sum, (act == ACT_ADD_PER) ? ivl : '0, act == ACT_ADD_PER);
				end
				ACT_DEL: begin
					drop_id(id);
				end
				default: begin
					k = 0;
					while (k < count && exps[k] <= t) begin
						f_id[k]  = ids[k];
						f_exp[k] = exps[k];
						f_per[k] = pers[k];
						f_prd[k] = prds[k];
						k++;
					end
					for (int i = 0; i < k; i++)
						drop_at(0);
					for (int i = 0; i < k; i++) begin
						f.id = f_id[i];
						f.last = (i + 1 == k);
						pending_fires.push_back(f);
						if (f_prd[i]) begin
							sum = f_exp[i] + f_per[i];
							insert(f_id[i], sum, f_per[i], 1'b1);
						end
					end
				end
			endcase
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			mismatches++;
		endtask

		task check_fired(logic [ID_W-1:0] id, logic lst);
			fire_t e;
			if (pending_fires.size() == 0) begin
				report($sformatf("unexpected beat fired_id=%0d last=%0b", id, lst));
				return;
			end
			e = pending_fires.pop_front();
			if (id !== e.id)
				report($sformatf("fired_id %0d, expected %0d", id, e.id));
			if (lst !== e.last)
				report($sformatf("last %0b, expected %0b (id %0d)", lst, e.last, e.id));
		endtask
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           action;
	logic [ID_W-1:0]      timer_id;
	logic [TIME_BITS-1:0] interval;
	logic [TIME_BITS-1:0] now;
	logic                 out_valid;
	logic                 out_stall;
	logic [ID_W-1:0]      fired_id;
	logic                 last;

	expiry_list timers = new();
	logic       hold_req;
	int         burst_left;

	sorted_timer_queue dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.timer_id (timer_id),
		.interval (interval),
		.now      (now),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fired_id (fired_id),
		.last     (last)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			timers.check_fired(fired_id, last);
	end

	// output backpressure: short and long stalls, quiet stretches, one long hold
	initial begin
		int stall_left;
		int quiet_left;
		int r;
		stall_left = 0;
		quiet_left = 0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = 400;
			end
			if (stall_left > 0) begin
				out_stall = 1'b1;
				stall_left--;
			end else if (quiet_left > 0) begin
				out_stall = 1'b0;
				quiet_left--;
			end else begin
				out_stall = 1'b0;
				r = $urandom_range(0, 99);
				if (r < 4)
					quiet_left = $urandom_range(50, 150);
				else if (r < 14)
					stall_left = (r < 12) ? $urandom_range(1, 3) : $urandom_range(15, 60);
			end
		end
	end

	task pause_in();
		int r;
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			burst_left = $urandom_range(10, 30);
		gap = (r < 60) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task send_item(action_t act, logic [ID_W-1:0] id, logic [TIME_BITS-1:0] ivl,
			logic [TIME_BITS-1:0] t);
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		timer_id = id;
		interval = ivl;
		now = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		timers.apply_item(act, id, ivl, t);
		pause_in();
	endtask

	initial begin
		#3000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		logic [TIME_BITS-1:0] sim_now;
		int                   r;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_ADD_ONE;
		timer_id = '0;
		interval = '0;
		now = '0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty tick, zero interval and zero period, deletes, wrap, full list
		send_item(ACT_TICK, 4'd0, 32'd0, 32'd0);
		send_item(ACT_ADD_ONE, 4'd0, 32'd0, 32'd0);
		send_item(ACT_ADD_PER, 4'd15, 32'd0, 32'd0);
		send_item(ACT_TICK, 4'd0, 32'd0, 32'd0);
		send_item(ACT_TICK, 4'd0, 32'd0, 32'd0);
		send_item(ACT_DEL, 4'd15, 32'd0, 32'd0);
		send_item(ACT_DEL, 4'd15, 32'd0, 32'd0);
		send_item(ACT_ADD_PER, 4'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_item(ACT_ADD_ONE, 4'd5, 32'h20, 32'hFFFF_FFF0);
		send_item(ACT_TICK, 4'd0, 32'd0, 32'h10);
		for (int i = 0; i < SLOTS; i++)
			send_item(ACT_ADD_ONE, 4'(15 - i), 32'(i % 4), 32'h100);
		send_item(ACT_ADD_PER, 4'd7, 32'd1, 32'h100);
		send_item(ACT_TICK, 4'd0, 32'd0, 32'hFFFF_FFFF);

		sim_now = 32'd1000;
		for (int n = 0; n < 305; n++) begin
			if (n == 150)
				hold_req = 1'b1;
			r = $urandom_range(0, 99);
			if (r < 30)
				send_item(ACT_ADD_ONE, 4'($urandom_range(0, 15)),
					($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 40)),
					sim_now);
			else if (r < 50)
				send_item(ACT_ADD_PER, 4'($urandom_range(0, 15)),
					32'($urandom_range(0, 30)), sim_now);
			else if (r < 62)
				send_item(ACT_DEL, 4'($urandom_range(0, 15)), 32'($urandom), 32'($urandom));
			else if (r < 95) begin
				sim_now = sim_now + 32'($urandom_range(0, 20));
				send_item(ACT_TICK, 4'($urandom_range(0, 15)), 32'($urandom), sim_now);
			end else
				send_item(action_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
					32'($urandom), 32'($urandom));
		end
		@(negedge clk);
		in_valid = 1'b0;

		while (timers.pending_fires.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		if (timers.mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
